// ===== rtl/ctc_pkg.sv =====
// Package for the token classifier: transfer types and the keyword table.
`timescale 1ns / 1ps

package ctc_pkg;

  localparam int KW_NUM     = 22;
  localparam int KW_MAX_LEN = 8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // String literals are right-justified: the last character sits in bits [7:0].
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_NUM] = '{
    "if", "else", "while", "do", "break", "continue", "int", "double",
    "float", "return", "char", "case", "sizeof", "long", "short",
    "typedef", "switch", "unsigned", "void", "static", "struct", "goto"
  };

  localparam int KW_LEN [KW_NUM] = '{
    2, 4, 5, 2, 5, 8, 3, 6,
    5, 6, 4, 4, 6, 4, 5,
    7, 6, 8, 4, 6, 6, 4
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic        keyword_found;
    logic        number_found;
    logic        operator_found;
    logic [15:0] keyword_total;
    logic [15:0] number_total;
    logic [15:0] operator_total;
    logic        line_done;
  } out_item_t;

  // Character j of keyword k, counted from the first character.
  // Only meaningful for j below the keyword length.
  function automatic logic [7:0] kw_byte(input int k, input int j);
    logic [KW_MAX_LEN*8-1:0] w;
    w = KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - j));
    return w[7:0];
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) ||
           (c == CHAR_SLASH) || (c == CHAR_GT) || (c == CHAR_LT) || (c == CHAR_EQ);
  endfunction

endpackage

// ===== rtl/c_token_classifier_counter.sv =====
// Top level of the token classifier: one character per transfer, flags and line totals out.
//
//   Channel  Ports                         Direction  Moves
//   in       in_valid, in_stall, in_data   into       one character and end-of-line mark
//   out      out_valid, out_stall, out_data out of    flags and running totals
//
// One character is taken every cycle while in_stall is low; its result passes the input register
// and then the result register before it is offered on out.
// Reset (synchronous, active low) empties both registers, the token and the counts.
// A stall on out holds the result; the input register then fills and in_stall rises.
`timescale 1ns / 1ps

module c_token_classifier_counter
  import ctc_pkg::*;
#(
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int LW = $clog2(MAX_KEYWORD_LEN + 2);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   s1_valid_r, s1_valid_nxt;
  in_item_t               s1_data_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [7:0]             tok_chars_r [MAX_KEYWORD_LEN];
  logic [7:0]             tok_chars_nxt [MAX_KEYWORD_LEN];
  logic [LW-1:0]          tok_len_r, tok_len_nxt;
  logic                   tok_digits_r, tok_digits_nxt;
  logic [COUNT_WIDTH-1:0] kw_cnt_r, kw_cnt_nxt;
  logic [COUNT_WIDTH-1:0] num_cnt_r, num_cnt_nxt;
  logic [COUNT_WIDTH-1:0] op_cnt_r, op_cnt_nxt;

  logic                   adv;
  logic                   in_acc;
  logic                   fire;

  logic [7:0]             c;
  logic                   eol, is_space, is_op, is_other, is_digit, close_tok;
  logic [7:0]             app_chars [MAX_KEYWORD_LEN];
  logic [LW-1:0]          app_len;
  logic [7:0]             cls_chars [MAX_KEYWORD_LEN];
  logic [LW-1:0]          cls_len;
  logic                   cls_digits;
  logic [KW_NUM-1:0]      kw_match;
  logic                   kw_hit, num_hit;
  logic [31:0]            kw_ext, num_ext, op_ext;

  // The result register moves on when it is empty or its content is taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s1_valid_r && adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_comb begin
    c        = s1_data_r.char_code;
    eol      = s1_data_r.end_of_line;
    is_space = (c == CHAR_SPACE);
    is_op    = is_operator(c);
    is_other = !is_space && !is_op;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

    // Token as it stands once this character has been appended.
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
      app_chars[i] = tok_chars_r[i];
      if (tok_len_r == LW'(i)) begin
        app_chars[i] = c;
      end
    end
    app_len = (tok_len_r <= LW'(MAX_KEYWORD_LEN)) ? tok_len_r + LW'(1) : tok_len_r;

    close_tok  = !is_other || eol;
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
      cls_chars[i] = is_other ? app_chars[i] : tok_chars_r[i];
    end
    cls_len    = is_other ? app_len : tok_len_r;
    cls_digits = tok_digits_r && (!is_other || is_digit);

    for (int k = 0; k < KW_NUM; k++) begin
      kw_match[k] = (cls_len == LW'(KW_LEN[k]));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < KW_LEN[k]) begin
          kw_match[k] = kw_match[k] && (cls_chars[j] == kw_byte(k, j));
        end
      end
    end

    kw_hit  = close_tok && (|kw_match);
    num_hit = close_tok && (cls_len != '0) && cls_digits;

    kw_cnt_nxt  = (kw_hit && kw_cnt_r != CNT_MAX) ? kw_cnt_r + COUNT_WIDTH'(1) : kw_cnt_r;
    num_cnt_nxt = (num_hit && num_cnt_r != CNT_MAX) ? num_cnt_r + COUNT_WIDTH'(1) : num_cnt_r;
    op_cnt_nxt  = (is_op && op_cnt_r != CNT_MAX) ? op_cnt_r + COUNT_WIDTH'(1) : op_cnt_r;

    kw_ext  = 32'(kw_cnt_nxt);
    num_ext = 32'(num_cnt_nxt);
    op_ext  = 32'(op_cnt_nxt);

    out_data_nxt.keyword_found  = kw_hit;
    out_data_nxt.number_found   = num_hit;
    out_data_nxt.operator_found = is_op;
    out_data_nxt.keyword_total  = kw_ext[15:0];
    out_data_nxt.number_total   = num_ext[15:0];
    out_data_nxt.operator_total = op_ext[15:0];
    out_data_nxt.line_done      = eol;

    // Stale bytes beyond the length never take part in a compare, so a closed
    // token only needs its length and digit flag cleared.
    tok_chars_nxt  = app_chars;
    tok_len_nxt    = close_tok ? '0 : app_len;
    tok_digits_nxt = close_tok ? 1'b1 : (tok_digits_r && is_digit);
    if (eol) begin
      kw_cnt_nxt  = '0;
      num_cnt_nxt = '0;
      op_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      tok_len_r    <= '0;
      tok_digits_r <= 1'b1;
      kw_cnt_r     <= '0;
      num_cnt_r    <= '0;
      op_cnt_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        tok_len_r    <= tok_len_nxt;
        tok_digits_r <= tok_digits_nxt;
        kw_cnt_r     <= kw_cnt_nxt;
        num_cnt_r    <= num_cnt_nxt;
        op_cnt_r     <= op_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r  <= out_data_nxt;
      tok_chars_r <= tok_chars_nxt;
    end
  end

`ifndef SYNTHESIS
  a_kw_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.keyword_found |-> out_data_r.keyword_total != 16'd0 ||
      COUNT_WIDTH > 16)
    else $error("keyword flagged but keyword total is zero");

  a_op_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.operator_found |-> out_data_r.operator_total != 16'd0 ||
      COUNT_WIDTH > 16)
    else $error("operator flagged but operator total is zero");

  a_kw_not_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.keyword_found && out_data_r.number_found))
    else $error("token classed as both keyword and number");

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_data_r.end_of_line |=>
      kw_cnt_r == '0 && num_cnt_r == '0 && op_cnt_r == '0 && tok_len_r == '0)
    else $error("counts or token not cleared after end of line");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tok_len_r <= LW'(MAX_KEYWORD_LEN + 1))
    else $error("token length beyond its saturation value");
`endif

endmodule
